[rtl/eap_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package eap_pkg;

  localparam int RECALL_STEPS_DEF = 11;
  localparam int COORD_BITS_DEF   = 12;

  localparam int CAT_W       = 4;
  localparam int CNT_W       = 16;
  localparam int Q_W         = 17;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TP,
    OP_FP
  } op_e;

  // One classified item, front to back.
  typedef struct packed {
    logic score;
    op_e  op;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic           start;
    logic [Q_W-1:0] rem_init;
    logic [Q_W-1:0] bits;
    logic [Q_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/eap_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface eap_item_if #(
  parameter int COORD_BITS = eap_pkg::COORD_BITS_DEF
) ();
  logic                      valid;
  logic                      ready;
  logic [eap_pkg::CAT_W-1:0] gt_category;
  logic [COORD_BITS-1:0]     gt_x;
  logic [COORD_BITS-1:0]     gt_y;
  logic [COORD_BITS-1:0]     gt_w;
  logic [COORD_BITS-1:0]     gt_h;
  logic                      pred_found;
  logic [COORD_BITS-1:0]     pred_x;
  logic [COORD_BITS-1:0]     pred_y;
  logic [COORD_BITS-1:0]     pred_w;
  logic [COORD_BITS-1:0]     pred_h;
  logic                      last_item;

  modport source (
    output valid, gt_category, gt_x, gt_y, gt_w, gt_h, pred_found,
           pred_x, pred_y, pred_w, pred_h, last_item,
    input  ready
  );
  modport sink (
    input  valid, gt_category, gt_x, gt_y, gt_w, gt_h, pred_found,
           pred_x, pred_y, pred_w, pred_h, last_item,
    output ready
  );
endinterface

interface eap_result_if ();
  logic                      valid;
  logic                      ready;
  logic [eap_pkg::Q_W-1:0]   average_precision;
  logic [eap_pkg::CNT_W-1:0] true_positive_total;
  logic [eap_pkg::CNT_W-1:0] false_positive_total;

  modport source (
    output valid, average_precision, true_positive_total, false_positive_total,
    input  ready
  );
  modport sink (
    input  valid, average_precision, true_positive_total, false_positive_total,
    output ready
  );
endinterface

`default_nettype wire

[rtl/eap_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module eap_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  eap_pkg::div_req_t req_i,
  output eap_pkg::div_rsp_t rsp_o
);
  import eap_pkg::*;

  localparam int DCNT_W = $clog2(Q_W + 1);

  logic [Q_W-1:0]    rem_q, rem_d;
  logic [Q_W-1:0]    bits_q, bits_d;
  logic [Q_W-1:0]    quot_q, quot_d;
  logic [Q_W-1:0]    dvs_q, dvs_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [Q_W:0]      trial;
  logic [Q_W:0]      diff;

  // Restoring division, one quotient bit a cycle.
  always_comb begin
    rem_d  = rem_q;
    bits_d = bits_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, bits_q[Q_W-1]};
    diff   = trial - {1'b0, dvs_q};
    if (req_i.start) begin
      rem_d  = req_i.rem_init;
      bits_d = req_i.bits;
      dvs_d  = req_i.divisor;
      quot_d = '0;
      cnt_d  = DCNT_W'(Q_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = diff[Q_W-1:0];
        quot_d = {quot_q[Q_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[Q_W-1:0];
        quot_d = {quot_q[Q_W-2:0], 1'b0};
      end
      bits_d = {bits_q[Q_W-2:0], 1'b0};
      cnt_d  = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

[rtl/eap_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module eap_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  eap_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output eap_pkg::cmd_t data_o,
  output logic          empty_o
);
  import eap_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

  cmd_t               slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W_Q-1:0] fill_q;
  logic               do_push, do_pop;

  assign full_o  = (fill_q == CNT_W_Q'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + CNT_W_Q'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - CNT_W_Q'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/eap_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module eap_front #(
  parameter int COORD_BITS = eap_pkg::COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  eap_item_if.sink                  item_i,
  input  logic [eap_pkg::CAT_W-1:0] target_i,
  output logic                      push_o,
  output eap_pkg::cmd_t             cmd_o,
  input  logic                      full_i
);
  import eap_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = 2 * CB;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OVL,
    S_MUL,
    S_CMP,
    S_PUSH
  } state_e;

  state_e        state_q;
  cmd_t          cmd_q;
  logic          accept;
  logic          score;

  logic [CB-1:0] gx_q, gy_q, gw_q, gh_q, px_q, py_q, pw_q, ph_q;
  logic [CB-1:0] ox_q, oy_q;
  logic [AW-1:0] inter_q, ga_q, pa_q;

  logic [CB-1:0] lo_x, lo_y;
  logic [CB:0]   ge_x, ge_y, pe_x, pe_y, hi_x, hi_y, ov_x, ov_y;
  logic [AW:0]   uni, twice;
  logic          hit;

  assign item_i.ready = (state_q == S_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign score        = (item_i.gt_category == target_i);
  assign push_o       = (state_q == S_PUSH) && !full_i;
  assign cmd_o        = cmd_q;

  // Half-open overlap on each axis.
  always_comb begin
    lo_x = (gx_q > px_q) ? gx_q : px_q;
    lo_y = (gy_q > py_q) ? gy_q : py_q;
    ge_x = {1'b0, gx_q} + {1'b0, gw_q};
    pe_x = {1'b0, px_q} + {1'b0, pw_q};
    ge_y = {1'b0, gy_q} + {1'b0, gh_q};
    pe_y = {1'b0, py_q} + {1'b0, ph_q};
    hi_x = (ge_x < pe_x) ? ge_x : pe_x;
    hi_y = (ge_y < pe_y) ? ge_y : pe_y;
    ov_x = (hi_x > {1'b0, lo_x}) ? hi_x - {1'b0, lo_x} : '0;
    ov_y = (hi_y > {1'b0, lo_y}) ? hi_y - {1'b0, lo_y} : '0;
    uni   = {1'b0, ga_q} + {1'b0, pa_q} - {1'b0, inter_q};
    twice = {inter_q, 1'b0};
    hit   = (uni != '0) && (twice >= uni);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '{score: 1'b0, op: OP_NONE, last: 1'b0};
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q.score <= score;
            cmd_q.op    <= OP_NONE;
            cmd_q.last  <= item_i.last_item;
            if (score && item_i.pred_found) begin
              state_q <= S_OVL;
            end else if (score || item_i.last_item) begin
              state_q <= S_PUSH;
            end
          end
        end
        S_OVL: state_q <= S_MUL;
        S_MUL: state_q <= S_CMP;
        S_CMP: begin
          cmd_q.op <= hit ? OP_TP : OP_FP;
          state_q  <= S_PUSH;
        end
        S_PUSH: begin
          if (!full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      gx_q <= item_i.gt_x;
      gy_q <= item_i.gt_y;
      gw_q <= item_i.gt_w;
      gh_q <= item_i.gt_h;
      px_q <= item_i.pred_x;
      py_q <= item_i.pred_y;
      pw_q <= item_i.pred_w;
      ph_q <= item_i.pred_h;
    end
    if (state_q == S_OVL) begin
      ox_q <= ov_x[CB-1:0];
      oy_q <= ov_y[CB-1:0];
    end
    if (state_q == S_MUL) begin
      inter_q <= ox_q * oy_q;
      ga_q    <= gw_q * gh_q;
      pa_q    <= pw_q * ph_q;
    end
  end

endmodule

`default_nettype wire

[rtl/eap_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module eap_back #(
  parameter int RECALL_STEPS = eap_pkg::RECALL_STEPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [eap_pkg::CNT_W-1:0] total_i,
  output logic                      pop_o,
  input  eap_pkg::cmd_t             cmd_i,
  input  logic                      empty_i,
  eap_result_if.source              result_o
);
  import eap_pkg::*;

  localparam int KW = $clog2(RECALL_STEPS);
  localparam int RW = CNT_W + KW;
  localparam int SW = Q_W + KW;
  localparam logic [KW-1:0] K_LAST = KW'(RECALL_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_STEP,
    S_STEP_END,
    S_SUM,
    S_SUM_END,
    S_MEAN,
    S_MEAN_WAIT,
    S_OUT
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   tp_q, fp_q, tp_n, fp_n;
  logic               last_q;
  logic [Q_W-1:0]     prec_q;
  logic [RW-1:0]      reach_q, thr_q;
  logic [KW-1:0]      k_q, k1_q;
  logic               s1_vld_q, reached_q;
  logic [SW-1:0]      sum_q;
  logic [RECALL_STEPS-1:0] vbit_q;
  logic               out_valid_q;
  logic [Q_W-1:0]     out_ap_q;
  logic [CNT_W-1:0]   out_tp_q, out_fp_q;

  logic [Q_W-1:0]     mem [RECALL_STEPS];
  logic [Q_W-1:0]     rdata_q;
  logic [Q_W-1:0]     eff;
  logic               mem_we;
  logic               in_step, in_sum;
  logic [Q_W-1:0]     seen;
  logic               out_free;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign seen     = {1'b0, tp_q} + {1'b0, fp_q};
  assign out_free = !out_valid_q || result_o.ready;
  assign in_step  = (state_q == S_STEP) || (state_q == S_STEP_END);
  assign in_sum   = (state_q == S_SUM) || (state_q == S_SUM_END);
  assign eff      = vbit_q[k1_q] ? rdata_q : '0;
  assign mem_we   = s1_vld_q && in_step && reached_q && (prec_q > eff);

  always_comb begin
    tp_n = tp_q;
    fp_n = fp_q;
    if (cmd_i.score && (cmd_i.op == OP_TP) && (tp_q != COUNT_MAX)) begin
      tp_n = tp_q + CNT_W'(1);
    end
    if (cmd_i.score && (cmd_i.op == OP_FP) && (fp_q != COUNT_MAX)) begin
      fp_n = fp_q + CNT_W'(1);
    end
  end

  // Shared divider: precision TP*2^16/seen, then the mean sum/RECALL_STEPS.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.rem_init = Q_W'(tp_q[CNT_W-1:1]);
    div_req.bits     = {tp_q[0], {(Q_W-1){1'b0}}};
    div_req.divisor  = seen;
    if (state_q == S_PREP) begin
      div_req.start = (seen != '0);
    end else if (state_q == S_MEAN) begin
      div_req.start    = 1'b1;
      div_req.rem_init = Q_W'(sum_q[SW-1:Q_W]);
      div_req.bits     = sum_q[Q_W-1:0];
      div_req.divisor  = Q_W'(RECALL_STEPS);
    end
  end

  eap_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[k1_q] <= prec_q;
    end
    rdata_q <= mem[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tp_q        <= '0;
      fp_q        <= '0;
      last_q      <= 1'b0;
      prec_q      <= '0;
      reach_q     <= '0;
      thr_q       <= '0;
      k_q         <= '0;
      k1_q        <= '0;
      s1_vld_q    <= 1'b0;
      reached_q   <= 1'b0;
      sum_q       <= '0;
      vbit_q      <= '0;
      out_valid_q <= 1'b0;
      out_ap_q    <= '0;
      out_tp_q    <= '0;
      out_fp_q    <= '0;
    end else begin
      s1_vld_q <= 1'b0;
      if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (mem_we) begin
        vbit_q[k1_q] <= 1'b1;
      end
      if (s1_vld_q && in_sum) begin
        sum_q <= sum_q + SW'(eff);
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            tp_q   <= tp_n;
            fp_q   <= fp_n;
            last_q <= cmd_i.last;
            k_q    <= '0;
            sum_q  <= '0;
            if (cmd_i.score) begin
              state_q <= S_PREP;
            end else if (cmd_i.last) begin
              state_q <= S_SUM;
            end
          end
        end
        S_PREP: begin
          reach_q <= RW'(RECALL_STEPS - 1) * RW'(tp_q);
          thr_q   <= '0;
          k_q     <= '0;
          if (seen != '0) begin
            state_q <= S_DIV;
          end else begin
            state_q <= last_q ? S_SUM : S_IDLE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            prec_q  <= div_rsp.quot;
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          s1_vld_q  <= 1'b1;
          k1_q      <= k_q;
          reached_q <= (reach_q >= thr_q);
          thr_q     <= thr_q + RW'(total_i);
          if (k_q == K_LAST) begin
            state_q <= S_STEP_END;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        S_STEP_END: begin
          k_q     <= '0;
          sum_q   <= '0;
          state_q <= last_q ? S_SUM : S_IDLE;
        end
        S_SUM: begin
          s1_vld_q <= 1'b1;
          k1_q     <= k_q;
          if (k_q == K_LAST) begin
            state_q <= S_SUM_END;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        S_SUM_END: state_q <= S_MEAN;
        S_MEAN:    state_q <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (div_rsp.done) begin
            prec_q  <= div_rsp.quot;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ap_q    <= prec_q;
            out_tp_q    <= tp_q;
            out_fp_q    <= fp_q;
            tp_q        <= '0;
            fp_q        <= '0;
            vbit_q      <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid                = out_valid_q;
  assign result_o.average_precision    = out_ap_q;
  assign result_o.true_positive_total  = out_tp_q;
  assign result_o.false_positive_total = out_fp_q;

endmodule

`default_nettype wire

[rtl/eleven_point_average_precision.sv]
`timescale 1ns / 1ps
`default_nettype none

// Eleven-point average precision of one object category.
// item_i: one ground-truth box per transfer, with the first prediction box of
//   the same category when pred_found is set; last_item closes the run.
// result_o: one transfer per run, after the item marked last: the mean of the
//   per-step precision maxima (Q16, 65536 = 1.0) and the saturated TP/FP counts.
// cfg_*: write target_category (index 0) and total_ground_truths (index 1)
//   while the block is idle; both reset to 1.
// Flow: the front takes an item only when done with the last (IoU test in
//   three steps) and hands a command for each scored or last item to a
//   4-entry queue. For a scored item the back runs the shared restoring
//   divider for the precision, then one recall step per cycle through the
//   step-maximum memory. The last item also sums the maxima and divides
//   the sum by RECALL_STEPS.
// Reset clears counts, valid bits of the step maxima and all handshakes.
// A stalled receiver holds the result in the output register; at the next
//   result the back waits, the queue fills and item_i.ready drops.
module eleven_point_average_precision #(
  parameter int RECALL_STEPS = eap_pkg::RECALL_STEPS_DEF,
  parameter int COORD_BITS   = eap_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [eap_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [eap_pkg::CFG_DATA_W-1:0] cfg_data_i,
  eap_item_if.sink                       item_i,
  eap_result_if.source                   result_o
);
  import eap_pkg::*;

  logic [CAT_W-1:0] target_q;
  logic [CNT_W-1:0] total_q;
  logic             push, full, pop, empty;
  cmd_t             cmd_in, cmd_out;

  // Configuration registers: take a write on every enabled edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= CAT_W'(1);
      total_q  <= CNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET: target_q <= cfg_data_i[CAT_W-1:0];
        CFG_TOTAL:  total_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: accept, filter by category, decide TP or FP from the IoU test.
  eap_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .target_i (target_q),
    .push_o   (push),
    .cmd_o    (cmd_in),
    .full_i   (full)
  );

  // Queue decouples the short front from the long back.
  eap_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .empty_o (empty)
  );

  // Back: counts, precision, step maxima, final mean and output register.
  eap_back #(
    .RECALL_STEPS (RECALL_STEPS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .total_i  (total_q),
    .pop_o    (pop),
    .cmd_i    (cmd_out),
    .empty_i  (empty),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

[rtl/eap_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module eap_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [eap_pkg::Q_W-1:0]   ap_i,
  input logic [eap_pkg::CNT_W-1:0] tp_i,
  input logic [eap_pkg::CNT_W-1:0] fp_i
);
  import eap_pkg::*;

  localparam logic [Q_W-1:0] Q16_ONE = Q_W'(65536);

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(ap_i) &&
      $stable(tp_i) && $stable(fp_i))
    else $error("result changed while stalled");

  // A mean of Q16 precisions never exceeds one.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> ap_i <= Q16_ONE)
    else $error("average precision above 1.0");

  // Without a true positive every precision was zero.
  a_no_tp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (tp_i == '0) |-> ap_i == '0)
    else $error("nonzero average precision with no true positive");

endmodule

bind eleven_point_average_precision eap_checker u_eap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .ap_i        (result_o.average_precision),
  .tp_i        (result_o.true_positive_total),
  .fp_i        (result_o.false_positive_total)
);

`default_nettype wire
